// File: src/ba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ba_pkg;

  localparam int unsigned POOL_BYTES   = 4096;
  localparam int unsigned MIN_BYTES    = 16;
  localparam int unsigned HEADER_BYTES = 16;

  localparam int unsigned TOP_ORDER  = $clog2(POOL_BYTES);
  localparam int unsigned LOW_ORDER  = $clog2(MIN_BYTES);
  localparam int unsigned UNIT_COUNT = POOL_BYTES / MIN_BYTES;
  localparam int unsigned UNIT_AW    = $clog2(UNIT_COUNT);
  localparam int unsigned ROW_COUNT  = TOP_ORDER - LOW_ORDER + 1;
  localparam int unsigned ROW_AW     = $clog2(ROW_COUNT);
  localparam int unsigned GRP_SIZE   = 16;
  localparam int unsigned GRP_AW     = $clog2(GRP_SIZE);
  localparam int unsigned GRP_COUNT  = UNIT_COUNT / GRP_SIZE;

  localparam int unsigned REQ_W = 13;
  localparam int unsigned OFF_W = 12;
  localparam int unsigned ORD_W = 4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ALLOC_OPEN,
    DP_FREE_OPEN,
    DP_RD,
    DP_RD_DOWN,
    DP_TREE,
    DP_TAKE,
    DP_NEXT_UP,
    DP_SPLIT_WR,
    DP_GRANT,
    DP_MERGE,
    DP_MARK,
    DP_ERR
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e err;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic pre_bad;
    logic so_bad;
    logic found;
    logic at_top;
    logic above_k;
    logic buddy_free;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: src/ba_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ba_datapath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ba_pkg::dp_cmd_t          cmd_i,
  output ba_pkg::dp_sts_t               sts_o,
  input  wire logic                     opcode_i,
  input  wire logic [ba_pkg::REQ_W-1:0] request_bytes_i,
  input  wire logic [ba_pkg::OFF_W-1:0] user_offset_i,
  input  wire logic                     out_stall_i,
  output logic                          out_valid_o,
  output ba_pkg::status_e               status_o,
  output logic [ba_pkg::OFF_W-1:0]      granted_offset_o,
  output logic [ba_pkg::ORD_W-1:0]      granted_order_o
);
  import ba_pkg::*;

  // One row per order; bit i of a row marks block i of that order as free.
  logic [UNIT_COUNT-1:0] row_mem [ROW_COUNT];
  logic [ROW_COUNT-1:0]  row_vld_q;
  logic [ORD_W-1:0]      so_mem [UNIT_COUNT];
  logic [UNIT_COUNT-1:0] so_vld_q;

  logic                  is_free_q, too_large_q, pre_bad_q;
  logic [ORD_W-1:0]      kneed_q, k_q, ord_q, so_rd_q;
  logic [OFF_W-1:0]      off_q;
  logic [UNIT_COUNT-1:0] row_q;
  logic [GRP_COUNT-1:0]  grp_any_q;
  logic [GRP_AW-1:0]     grp_idx_q [GRP_COUNT];
  status_e               res_status_q;
  logic [OFF_W-1:0]      res_off_q;
  logic [ORD_W-1:0]      res_ord_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [OFF_W-1:0]      out_off_q;
  logic [ORD_W-1:0]      out_ord_q;

  logic [REQ_W:0]        need_c;
  logic [ORD_W-1:0]      kneed_c;
  logic                  too_large_c;
  logic [OFF_W-1:0]      off_c;
  logic                  pre_bad_c;
  logic [15:0]           kmask_c;
  logic                  so_bad_c;
  logic                  found_c;
  logic [UNIT_AW-1:0]    take_idx_c;
  logic [OFF_W-1:0]      take_off_c;
  logic [UNIT_AW-1:0]    blk_idx_c;
  logic [UNIT_AW-1:0]    buddy_idx_c;
  logic [ROW_AW-1:0]     rd_addr_c, wr_addr_c;
  logic                  wr_en_c;
  logic [UNIT_COUNT-1:0] wr_data_c;
  logic [UNIT_AW-1:0]    so_addr_c;
  logic [UNIT_AW-1:0]    so_cur_c;
  logic [GRP_AW-1:0]     grp_idx_c [GRP_COUNT];

  always_comb begin
    need_c      = {1'b0, request_bytes_i} + (REQ_W+1)'(HEADER_BYTES);
    too_large_c = 32'(need_c) > POOL_BYTES;
    kneed_c     = ORD_W'(TOP_ORDER);
    for (int o = TOP_ORDER; o >= LOW_ORDER; o--) begin
      if (32'(need_c) <= (32'd1 << o)) kneed_c = ORD_W'(o);
    end
    off_c     = user_offset_i - OFF_W'(HEADER_BYTES);
    pre_bad_c = (32'(user_offset_i) < HEADER_BYTES)
             || ((32'(off_c) & (MIN_BYTES - 1)) != 0)
             || (32'(off_c) >= POOL_BYTES);
    so_addr_c = off_c[LOW_ORDER +: UNIT_AW];
    so_cur_c  = off_q[LOW_ORDER +: UNIT_AW];
  end

  always_comb begin
    kmask_c  = (16'd1 << so_rd_q) - 16'd1;
    so_bad_c = (32'(so_rd_q) < LOW_ORDER) || (32'(so_rd_q) > TOP_ORDER)
            || ((16'(off_q) & kmask_c) != 16'd0);
  end

  // First level of the first-free search: lowest set bit within each group.
  always_comb begin
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_idx_c[g] = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (row_q[g*GRP_SIZE + b]) grp_idx_c[g] = GRP_AW'(b);
      end
    end
  end

  // Second level of the first-free search over the registered group flags.
  always_comb begin
    found_c    = 1'b0;
    take_idx_c = '0;
    for (int g = GRP_COUNT - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found_c    = 1'b1;
        take_idx_c = UNIT_AW'(g * GRP_SIZE) | UNIT_AW'(grp_idx_q[g]);
      end
    end
    take_off_c = OFF_W'(take_idx_c) << ord_q;
  end

  always_comb begin
    blk_idx_c   = UNIT_AW'(off_q >> ord_q);
    buddy_idx_c = blk_idx_c ^ UNIT_AW'(1);
    rd_addr_c   = (cmd_i.op == DP_RD_DOWN) ? ROW_AW'(ord_q - ORD_W'(LOW_ORDER + 1))
                                           : ROW_AW'(ord_q - ORD_W'(LOW_ORDER));
    wr_addr_c   = ROW_AW'(ord_q - ORD_W'(LOW_ORDER));
    wr_data_c   = row_q;
    wr_en_c     = 1'b1;
    case (cmd_i.op)
      DP_TAKE:     wr_data_c[take_idx_c] = 1'b0;
      DP_SPLIT_WR: wr_data_c[blk_idx_c | UNIT_AW'(1)] = 1'b1;
      DP_MERGE:    wr_data_c[buddy_idx_c] = 1'b0;
      DP_MARK:     wr_data_c[blk_idx_c] = 1'b1;
      default:     wr_en_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_c) row_mem[wr_addr_c] <= wr_data_c;
    if (cmd_i.op == DP_RD || cmd_i.op == DP_RD_DOWN) begin
      if (row_vld_q[rd_addr_c]) begin
        row_q <= row_mem[rd_addr_c];
      end else begin
        // Out of reset only the whole pool is free.
        row_q <= (32'(rd_addr_c) == ROW_COUNT - 1) ? UNIT_COUNT'(1) : '0;
      end
    end
    if (cmd_i.op == DP_GRANT) so_mem[so_cur_c] <= k_q;
    if (cmd_i.op == DP_LOAD) so_rd_q <= so_vld_q[so_addr_c] ? so_mem[so_addr_c] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      so_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en_c) row_vld_q[wr_addr_c] <= 1'b1;
      if (cmd_i.op == DP_GRANT) so_vld_q[so_cur_c] <= 1'b1;
      if (cmd_i.op == DP_FREE_OPEN) so_vld_q[so_cur_c] <= 1'b0;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_off_q    <= res_off_q;
      out_ord_q    <= res_ord_q;
    end
    for (int g = 0; g < GRP_COUNT; g++) begin
      if (cmd_i.op == DP_TREE) begin
        grp_any_q[g] <= |row_q[g*GRP_SIZE +: GRP_SIZE];
        grp_idx_q[g] <= grp_idx_c[g];
      end
    end
    case (cmd_i.op)
      DP_LOAD: begin
        is_free_q   <= opcode_i;
        too_large_q <= too_large_c;
        pre_bad_q   <= pre_bad_c;
        kneed_q     <= kneed_c;
        off_q       <= off_c;
      end
      DP_ALLOC_OPEN: begin
        ord_q <= kneed_q;
        k_q   <= kneed_q;
        off_q <= '0;
      end
      DP_FREE_OPEN: ord_q <= so_rd_q;
      DP_RD_DOWN:   ord_q <= ord_q - ORD_W'(1);
      DP_TAKE:      off_q <= take_off_c;
      DP_NEXT_UP:   ord_q <= ord_q + ORD_W'(1);
      DP_GRANT: begin
        res_status_q <= ST_OK;
        res_off_q    <= off_q + OFF_W'(HEADER_BYTES);
        res_ord_q    <= k_q;
      end
      DP_MERGE: begin
        off_q <= off_q & ~(OFF_W'(1) << ord_q);
        ord_q <= ord_q + ORD_W'(1);
      end
      DP_MARK: begin
        res_status_q <= ST_OK;
        res_off_q    <= '0;
        res_ord_q    <= ord_q;
      end
      DP_ERR: begin
        res_status_q <= cmd_i.err;
        res_off_q    <= '0;
        res_ord_q    <= '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.is_free    = is_free_q;
    sts_o.too_large  = too_large_q;
    sts_o.pre_bad    = pre_bad_q;
    sts_o.so_bad     = so_bad_c;
    sts_o.found      = found_c;
    sts_o.at_top     = 32'(ord_q) == TOP_ORDER;
    sts_o.above_k    = ord_q > k_q;
    sts_o.buddy_free = row_q[buddy_idx_c];
    sts_o.out_busy   = out_valid_q && out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_offset_o = out_off_q;
  assign granted_order_o  = out_ord_q;

endmodule

`default_nettype wire

// File: src/ba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ba_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire ba_pkg::dp_sts_t sts_i,
  output ba_pkg::dp_cmd_t      cmd_o
);
  import ba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_A_RD,
    S_A_T1,
    S_A_T2,
    S_A_SCHK,
    S_A_SW,
    S_M_CHK,
    S_M_TST,
    S_M_SET,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.op       = DP_NOP;
    cmd_o.err      = ST_OK;
    cmd_o.out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.is_free) begin
          if (sts_i.too_large) begin
            cmd_o.op  = DP_ERR;
            cmd_o.err = ST_TOO_LARGE;
            state_d   = S_FIN;
          end else begin
            cmd_o.op = DP_ALLOC_OPEN;
            state_d  = S_A_RD;
          end
        end else if (sts_i.pre_bad || sts_i.so_bad) begin
          cmd_o.op  = DP_ERR;
          cmd_o.err = ST_BAD_FREE;
          state_d   = S_FIN;
        end else begin
          cmd_o.op = DP_FREE_OPEN;
          state_d  = S_M_CHK;
        end
      end
      S_A_RD: begin
        cmd_o.op = DP_RD;
        state_d  = S_A_T1;
      end
      S_A_T1: begin
        cmd_o.op = DP_TREE;
        state_d  = S_A_T2;
      end
      S_A_T2: begin
        if (sts_i.found) begin
          cmd_o.op = DP_TAKE;
          state_d  = S_A_SCHK;
        end else if (sts_i.at_top) begin
          cmd_o.op  = DP_ERR;
          cmd_o.err = ST_NO_SPACE;
          state_d   = S_FIN;
        end else begin
          cmd_o.op = DP_NEXT_UP;
          state_d  = S_A_RD;
        end
      end
      S_A_SCHK: begin
        if (sts_i.above_k) begin
          cmd_o.op = DP_RD_DOWN;
          state_d  = S_A_SW;
        end else begin
          cmd_o.op = DP_GRANT;
          state_d  = S_FIN;
        end
      end
      S_A_SW: begin
        cmd_o.op = DP_SPLIT_WR;
        state_d  = S_A_SCHK;
      end
      S_M_CHK: begin
        cmd_o.op = DP_RD;
        state_d  = sts_i.at_top ? S_M_SET : S_M_TST;
      end
      S_M_TST: begin
        if (sts_i.buddy_free) begin
          cmd_o.op = DP_MERGE;
          state_d  = S_M_CHK;
        end else begin
          state_d = S_M_SET;
        end
      end
      S_M_SET: begin
        cmd_o.op = DP_MARK;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: src/buddy_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Fields
// request   in         in_valid_i / in_stall_o opcode_i, request_bytes_i, user_offset_i
// result    out        out_valid_o / out_stall_i status_o, granted_offset_o, granted_order_o
//
// One request at a time. An allocate searches one order per pass (read, tree, test)
// upward from the needed order, then splits down one order per pass before the grant;
// a free merges up one order per pass; a rejected request goes straight to its result.
// The free-map memory holds one row per order and is read and written one per step.
// Reset clears the valid bits of both stores at once; no clearing pass is needed.
// A result waits in the output register while out_stall_i is high; the next request
// is taken once the current one has reached that register.

module buddy_allocator (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     opcode_i,
  input  wire logic [ba_pkg::REQ_W-1:0] request_bytes_i,
  input  wire logic [ba_pkg::OFF_W-1:0] user_offset_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [1:0]                    status_o,
  output logic [ba_pkg::OFF_W-1:0]      granted_offset_o,
  output logic [ba_pkg::ORD_W-1:0]      granted_order_o
);
  import ba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  status_e status;

  ba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ba_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .request_bytes_i  (request_bytes_i),
    .user_offset_i    (user_offset_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status),
    .granted_offset_o (granted_offset_o),
    .granted_order_o  (granted_order_o)
  );

  assign status_o = status;

  // A taken request closes the input until its result is loaded into the output register.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another was in progress");

  // Error results carry no offset and no order.
  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status != ST_OK) |-> (granted_offset_o == '0 && granted_order_o == '0))
    else $error("error result with nonzero fields");

  // Every successful result names an order within the pool.
  a_ok_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status == ST_OK) |->
      (32'(granted_order_o) >= LOW_ORDER && 32'(granted_order_o) <= TOP_ORDER))
    else $error("granted order out of range");

endmodule

`default_nettype wire
